FILE: hdl/imf_pkg.sv
// Shared types, constants and register codes of the image median filter.
package imf_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_RADIUS = 3;
    localparam int DEF_PIXEL_BITS = 16;

    localparam int PIX_PORT_BITS  = 16;
    localparam int CFG_ADDR_BITS  = 2;
    localparam int CFG_DATA_BITS  = 16;
    localparam int CFG_W_BITS     = 11;
    localparam int CFG_H_BITS     = 16;
    localparam int CFG_R_BITS     = 2;
    localparam int RAD_BITS       = 3;
    localparam int ROW_BITS       = 16;
    localparam int OFIFO_DEPTH    = 8;

    localparam logic [CFG_W_BITS-1:0] RST_WIDTH  = 11'd1024;
    localparam logic [CFG_H_BITS-1:0] RST_HEIGHT = 16'd1024;
    localparam logic [CFG_R_BITS-1:0] RST_RADIUS = 2'd1;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        CFG_IMAGE_WIDTH,
        CFG_IMAGE_HEIGHT,
        CFG_RADIUS,
        CFG_PIXEL_SIGNED
    } t_cfg_idx;

    typedef enum logic {
        OP_PIXEL,
        OP_DRAIN
    } t_op;

    typedef struct packed {
        logic valid;
        logic last;
    } t_win_ctl;

endpackage

FILE: hdl/image_median_filter_top.sv
// Streaming square-window median filter: line store, column fetch and output queue.
//
// Input channel (s_axis): one transfer per item; tuser is the op (pixel or drain),
// tdata the raw pixel. Pixels come in raster order; drain items flush the rows
// still pending after the last pixel of a frame. Output channel (m_axis): tdata
// is the window median, tlast marks the last pixel of the frame.
// Configuration: i_cfg_we writes register i_cfg_addr (width, height, radius,
// signed compare) at a clock edge; write only while no results are pending.
// Throughput: one item per cycle, except that the first result of every row
// fetches radius+1 columns from the line store through its single read port,
// so input is held off while those extra columns are read at each row start.
// Path: a result passes the fetch, line store read, window and median stage registers
// and the output queue before m_axis offers it (plus the extra reads at a row start).
// The line store is one memory with one column of all row slots per word.
// When the receiver stalls, results collect in an 8-entry output queue; input is
// held off only once queued plus in-flight results would fill it.
// Reset (synchronous, active low) clears the counters, pipeline and queue and
// loads the default configuration; line store contents are left as they are.
module image_median_filter_top
    import imf_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_RADIUS = DEF_MAX_RADIUS,
    parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_ADDR_BITS-1:0] i_cfg_addr,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [PIX_PORT_BITS-1:0] s_axis_tdata,   // [15:0] pixel
    input  logic                     s_axis_tuser,   // [0] op
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [PIX_PORT_BITS-1:0] m_axis_tdata,   // [15:0] median
    output logic                     m_axis_tlast
);

    localparam int SLOTS = 2 * MAX_RADIUS + 2;
    localparam int SIDE  = 2 * MAX_RADIUS + 1;
    localparam int WIN   = SIDE * SIDE;
    localparam int SW    = $clog2(SLOTS);
    localparam int CW    = $clog2(MAX_WIDTH + 1);
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int QW    = $clog2(OFIFO_DEPTH);
    localparam int CRW   = $clog2(OFIFO_DEPTH + 1);

    // configuration
    logic [CFG_W_BITS-1:0] r_cfg_width;
    logic [CFG_H_BITS-1:0] r_cfg_height;
    logic [CFG_R_BITS-1:0] r_cfg_radius;
    logic                  r_cfg_signed;

    logic [CW-1:0]         c_w;
    logic [ROW_BITS-1:0]   c_h;
    logic [RAD_BITS-1:0]   c_r;

    // input and output position
    logic [CW-1:0]         r_in_col, n_in_col;
    logic [ROW_BITS-1:0]   r_in_row, n_in_row;
    logic [SW-1:0]         r_in_slot, n_in_slot;
    logic [XW-1:0]         r_out_x;
    logic [ROW_BITS-1:0]   r_out_y;
    logic [SW-1:0]         r_out_slot;

    logic                  acc;
    logic                  wr_en;
    logic [XW-1:0]         wr_col;
    logic [SW-1:0]         wr_slot;
    logic                  ready;
    logic                  last_pos;
    logic                  emit;
    logic [SW-1:0]         row_slot [SIDE];

    // column fetch
    logic                  r_a_valid;
    logic [XW-1:0]         r_a_col;
    logic                  r_a_fill;
    logic                  r_a_emit;
    logic                  r_a_last;
    logic [SW-1:0]         r_a_slots [SIDE];
    logic [RAD_BITS-1:0]   r_left;

    logic [SLOTS-1:0][PIXEL_BITS-1:0] r_mem [MAX_WIDTH];
    logic [SLOTS-1:0][PIXEL_BITS-1:0] r_word;

    logic                  r_b_valid;
    logic                  r_b_fill;
    logic                  r_b_emit;
    logic                  r_b_last;
    logic [SW-1:0]         r_b_slots [SIDE];
    logic [PIXEL_BITS-1:0] sel [SIDE];

    logic [PIXEL_BITS-1:0] r_cols [SIDE][SIDE];
    t_win_ctl              r_c_ctl;
    logic [PIXEL_BITS-1:0] win [WIN];

    t_win_ctl              med_ctl;
    logic [PIXEL_BITS-1:0] med_val;

    // output queue
    logic [PIXEL_BITS:0]   r_q [OFIFO_DEPTH];
    logic [QW-1:0]         r_q_wp, r_q_rp;
    logic [CRW-1:0]        r_q_cnt;
    logic [CRW-1:0]        r_credit;
    logic                  pop;

    // ---------------------------------------------------------------- config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= RST_WIDTH;
            r_cfg_height <= RST_HEIGHT;
            r_cfg_radius <= RST_RADIUS;
            r_cfg_signed <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_IMAGE_WIDTH:  r_cfg_width  <= i_cfg_data[CFG_W_BITS-1:0];
                CFG_IMAGE_HEIGHT: r_cfg_height <= i_cfg_data[CFG_H_BITS-1:0];
                CFG_RADIUS:       r_cfg_radius <= i_cfg_data[CFG_R_BITS-1:0];
                CFG_PIXEL_SIGNED: r_cfg_signed <= i_cfg_data[0];
                default:          r_cfg_signed <= r_cfg_signed;
            endcase
        end
    end

    always_comb begin
        if (r_cfg_width == '0) begin
            c_w = CW'(1);
        end else if (32'(r_cfg_width) > 32'(MAX_WIDTH)) begin
            c_w = CW'(MAX_WIDTH);
        end else begin
            c_w = CW'(r_cfg_width);
        end
        c_h = (r_cfg_height == '0) ? ROW_BITS'(1) : r_cfg_height;
        c_r = (32'(r_cfg_radius) > 32'(MAX_RADIUS)) ? RAD_BITS'(MAX_RADIUS)
                                                    : RAD_BITS'(r_cfg_radius);
    end

    // ------------------------------------------------------- position update
    assign s_axis_tready = (r_left == '0) && (r_credit < CRW'(OFIFO_DEPTH));
    assign acc = s_axis_tvalid && s_axis_tready;

    always_comb begin
        logic [16:0]   ry_sum;
        logic [16:0]   ry;
        logic [CW:0]   rx_sum;
        logic [CW:0]   rx;
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_in_slot = r_in_slot;
        wr_en     = 1'b0;
        wr_col    = '0;
        wr_slot   = '0;
        if ((t_op'(s_axis_tuser) == OP_PIXEL) && (r_in_row < c_h)) begin
            if (n_in_col >= c_w) begin
                n_in_col  = '0;
                n_in_row  = n_in_row + 1'b1;
                n_in_slot = (n_in_slot == SW'(SLOTS - 1)) ? '0 : n_in_slot + 1'b1;
            end
            if (n_in_row < c_h) begin
                wr_en     = 1'b1;
                wr_col    = n_in_col[XW-1:0];
                wr_slot   = n_in_slot;
                n_in_col  = n_in_col + 1'b1;
                if (n_in_col >= c_w) begin
                    n_in_col  = '0;
                    n_in_row  = n_in_row + 1'b1;
                    n_in_slot = (n_in_slot == SW'(SLOTS - 1)) ? '0 : n_in_slot + 1'b1;
                end
            end
        end
        ry_sum = 17'(r_out_y) + 17'(c_r);
        ry     = (ry_sum > 17'(c_h) - 17'd1) ? 17'(c_h) - 17'd1 : ry_sum;
        rx_sum = (CW+1)'(r_out_x) + (CW+1)'(c_r);
        rx     = (rx_sum > (CW+1)'(c_w) - 1'b1) ? (CW+1)'(c_w) - 1'b1 : rx_sum;
        ready  = (n_in_row >= c_h) || (17'(n_in_row) > ry) ||
                 ((17'(n_in_row) == ry) && ((CW+1)'(n_in_col) > rx));
        last_pos = (CW'(r_out_x) == c_w - 1'b1) && (r_out_y == c_h - 1'b1);
    end

    assign emit = acc && ready;

    // line store slot of each window row, rows clamped to the frame
    always_comb begin
        int d;
        int dd;
        int yi;
        int s;
        yi = int'(r_out_y);
        for (int dy = 0; dy < SIDE; dy++) begin
            d  = dy - int'(c_r);
            dd = d;
            if (yi + d < 0) begin
                dd = -yi;
            end else if (yi + d > int'(c_h) - 1) begin
                dd = int'(c_h) - 1 - yi;
            end
            s = int'(r_out_slot) + dd;
            if (s < 0) begin
                s = s + SLOTS;
            end else if (s >= SLOTS) begin
                s = s - SLOTS;
            end
            if (dy > 2 * int'(c_r)) begin
                s = 0;
            end
            row_slot[dy] = SW'(s);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_in_slot  <= '0;
            r_out_x    <= '0;
            r_out_y    <= '0;
            r_out_slot <= '0;
        end else if (acc) begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_in_slot <= n_in_slot;
            if (emit) begin
                if (last_pos) begin
                    r_in_col   <= '0;
                    r_in_row   <= '0;
                    r_in_slot  <= '0;
                    r_out_x    <= '0;
                    r_out_y    <= '0;
                    r_out_slot <= '0;
                end else if (CW'(r_out_x) + 1'b1 >= c_w) begin
                    r_out_x    <= '0;
                    r_out_y    <= r_out_y + 1'b1;
                    r_out_slot <= (r_out_slot == SW'(SLOTS - 1)) ? '0 : r_out_slot + 1'b1;
                end else begin
                    r_out_x <= r_out_x + 1'b1;
                end
            end
        end
    end

    // ---------------------------------------------------------- column fetch
    // A row start reads columns 0..r; every other result reads column x+r.
    always_ff @(posedge i_clk) begin
        logic [CW-1:0] x_r;
        logic [CW-1:0] nxt;
        x_r = CW'(r_out_x) + CW'(c_r);
        nxt = CW'(r_a_col) + 1'b1;
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_left    <= '0;
        end else if (emit) begin
            r_a_valid <= 1'b1;
            r_a_fill  <= (r_out_x == '0);
            r_a_emit  <= (r_out_x != '0) || (c_r == '0);
            r_left    <= (r_out_x == '0) ? c_r : '0;
            r_a_last  <= last_pos;
            r_a_slots <= row_slot;
            if (r_out_x == '0) begin
                r_a_col <= '0;
            end else begin
                r_a_col <= (x_r > c_w - 1'b1) ? XW'(c_w - 1'b1) : XW'(x_r);
            end
        end else if (r_left != '0) begin
            r_a_valid <= 1'b1;
            r_a_fill  <= 1'b0;
            r_a_emit  <= (r_left == RAD_BITS'(1));
            r_left    <= r_left - 1'b1;
            r_a_col   <= (nxt > c_w - 1'b1) ? XW'(c_w - 1'b1) : XW'(nxt);
        end else begin
            r_a_valid <= 1'b0;
        end
    end

    // line store: reads see writes of earlier edges only
    always_ff @(posedge i_clk) begin
        if (wr_en && acc) begin
            r_mem[wr_col][wr_slot] <= s_axis_tdata[PIXEL_BITS-1:0];
        end
        r_word <= r_mem[r_a_col];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= r_a_valid;
        end
        r_b_fill  <= r_a_fill;
        r_b_emit  <= r_a_emit;
        r_b_last  <= r_a_last;
        r_b_slots <= r_a_slots;
    end

    always_comb begin
        for (int dy = 0; dy < SIDE; dy++) begin
            sel[dy] = r_word[r_b_slots[dy]];
        end
    end

    // window columns; newest column sits at the top index
    always_ff @(posedge i_clk) begin
        if (r_b_valid) begin
            if (r_b_fill) begin
                for (int c = 0; c < SIDE; c++) begin
                    r_cols[c] <= sel;
                end
            end else begin
                for (int c = 0; c < SIDE - 1; c++) begin
                    r_cols[c] <= r_cols[c+1];
                end
                r_cols[SIDE-1] <= sel;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_ctl <= '0;
        end else begin
            r_c_ctl.valid <= r_b_valid && r_b_emit;
            r_c_ctl.last  <= r_b_last;
        end
    end

    always_comb begin
        for (int c = 0; c < SIDE; c++) begin
            for (int dy = 0; dy < SIDE; dy++) begin
                win[c*SIDE+dy] = r_cols[c][dy];
            end
        end
    end

    imf_median #(
        .MAX_RADIUS (MAX_RADIUS),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_median (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (r_c_ctl),
        .i_win          (win),
        .i_radius       (c_r),
        .i_pixel_signed (r_cfg_signed),
        .o_ctl          (med_ctl),
        .o_median       (med_val)
    );

    // ---------------------------------------------------------- output queue
    assign pop = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_wp   <= '0;
            r_q_rp   <= '0;
            r_q_cnt  <= '0;
            r_credit <= '0;
        end else begin
            if (med_ctl.valid) begin
                r_q_wp <= r_q_wp + 1'b1;
            end
            if (pop) begin
                r_q_rp <= r_q_rp + 1'b1;
            end
            r_q_cnt  <= r_q_cnt + CRW'(med_ctl.valid) - CRW'(pop);
            r_credit <= r_credit + CRW'(emit) - CRW'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (med_ctl.valid) begin
            r_q[r_q_wp] <= {med_ctl.last, med_val};
        end
    end

    assign m_axis_tvalid = (r_q_cnt != '0);
    assign m_axis_tdata  = PIX_PORT_BITS'(r_q[r_q_rp][PIXEL_BITS-1:0]);
    assign m_axis_tlast  = r_q[r_q_rp][PIXEL_BITS];

endmodule

FILE: hdl/imf_median.sv
// Pipelined rank selector: exact median of the current square window.
module imf_median
    import imf_pkg::*;
#(
    parameter int MAX_RADIUS = DEF_MAX_RADIUS,
    parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_win_ctl              i_ctl,
    input  logic [PIXEL_BITS-1:0] i_win [(2*MAX_RADIUS+1)*(2*MAX_RADIUS+1)],
    input  logic [RAD_BITS-1:0]   i_radius,
    input  logic                  i_pixel_signed,
    output t_win_ctl              o_ctl,
    output logic [PIXEL_BITS-1:0] o_median
);

    localparam int Side = 2 * MAX_RADIUS + 1;
    localparam int Win  = Side * Side;
    localparam int CNTW = $clog2(Win + 1);

    logic [PIXEL_BITS-1:0] key [Win];
    logic [Win-1:0]        mask;
    logic [CNTW-1:0]       k_rank;

    // stage 1: pairwise compares
    t_win_ctl              r1_ctl;
    logic [Win-1:0]        r1_lt [Win];
    logic [Win-1:0]        r1_le [Win];
    logic [PIXEL_BITS-1:0] r1_val [Win];
    logic [Win-1:0]        r1_mask;
    logic [CNTW-1:0]       r1_k;

    // stage 2: counts
    t_win_ctl              r2_ctl;
    logic [CNTW-1:0]       r2_less [Win];
    logic [CNTW-1:0]       r2_le [Win];
    logic [PIXEL_BITS-1:0] r2_val [Win];
    logic [Win-1:0]        r2_mask;
    logic [CNTW-1:0]       r2_k;

    // stage 3: select
    t_win_ctl              r3_ctl;
    logic [PIXEL_BITS-1:0] r3_med;
    logic [PIXEL_BITS-1:0] n_med;

    always_comb begin
        int c;
        int dy;
        int lo;
        lo = Side - 1 - 2 * int'(i_radius);
        for (int i = 0; i < Win; i++) begin
            c  = i / Side;
            dy = i % Side;
            key[i]  = i_win[i] ^ (i_pixel_signed ? {1'b1, {(PIXEL_BITS-1){1'b0}}} : '0);
            mask[i] = (c >= lo) && (dy <= 2 * int'(i_radius));
        end
        // rank n/2 of n = (2r+1)^2 values is 2r(r+1)
        k_rank = CNTW'(2 * int'(i_radius) * (int'(i_radius) + 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl <= '0;
            r2_ctl <= '0;
            r3_ctl <= '0;
        end else begin
            r1_ctl <= i_ctl;
            r2_ctl <= r1_ctl;
            r3_ctl <= r2_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < Win; i++) begin
            for (int j = 0; j < Win; j++) begin
                r1_lt[i][j] <= mask[j] && (key[j] < key[i]);
                r1_le[i][j] <= mask[j] && (key[j] <= key[i]);
            end
            r1_val[i] <= i_win[i];
        end
        r1_mask <= mask;
        r1_k    <= k_rank;

        for (int i = 0; i < Win; i++) begin
            r2_less[i] <= CNTW'($countones(r1_lt[i]));
            r2_le[i]   <= CNTW'($countones(r1_le[i]));
            r2_val[i]  <= r1_val[i];
        end
        r2_mask <= r1_mask;
        r2_k    <= r1_k;

        r3_med <= n_med;
    end

    // every matching element carries the same value, so an OR picks it
    always_comb begin
        n_med = '0;
        for (int i = 0; i < Win; i++) begin
            if (r2_mask[i] && (r2_less[i] <= r2_k) && (r2_k < r2_le[i])) begin
                n_med = n_med | r2_val[i];
            end
        end
    end

    assign o_ctl    = r3_ctl;
    assign o_median = r3_med;

endmodule
